@@ rtl/cle_pkg.sv @@
// ----------------------------------------------------------------------------
// Console line editor package
// Shared constants, command codes and payload types.
// ----------------------------------------------------------------------------
package cle_pkg;

  localparam int LINE_DEPTH = 64;
  localparam int ADDR_W     = $clog2(LINE_DEPTH);
  localparam int LEN_W      = 7;

  localparam logic [1:0] CMD_RECV  = 2'd0;
  localparam logic [1:0] CMD_CLEAR = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_ESC   = 8'h1b;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_SEQ   = 8'h5b;
  localparam logic [7:0] CH_DEL   = 8'h7f;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] ch;
    logic [5:0] index;
  } item_t;

  typedef struct packed {
    logic             echo_valid;
    logic [7:0]       echo_byte;
    logic             status;
    logic             line_ready;
    logic [LEN_W-1:0] line_length;
    logic [7:0]       read_byte;
    logic             last;
  } result_t;

  // One finished item on its way to the output stage.
  typedef struct packed {
    result_t res;
    logic    triple;
  } job_t;

endpackage

@@ rtl/cle_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data (read-first).
// ----------------------------------------------------------------------------
module cle_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ rtl/cle_out.sv @@
// ----------------------------------------------------------------------------
// Console line editor output stage
// Holds one finished item and plays it out as one or three result transfers.
// ----------------------------------------------------------------------------
module cle_out (
  input  logic              clk,
  input  logic              rst,
  input  logic              job_valid,
  output logic              job_ready,
  input  cle_pkg::job_t     job,
  output logic              result_valid,
  input  logic              result_ready,
  output cle_pkg::result_t  result
);

  logic          full;
  logic [1:0]    beat;
  cle_pkg::job_t held;
  logic          done_beat;
  logic          take_out;

  assign done_beat = !held.triple || (beat == 2'd2);
  assign take_out  = full && result_ready;
  assign job_ready = !full || (result_ready && done_beat);

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
      beat <= 2'd0;
    end else if (job_valid && job_ready) begin
      full <= 1'b1;
      beat <= 2'd0;
      held <= job;
    end else if (take_out) begin
      if (done_beat) begin
        full <= 1'b0;
        beat <= 2'd0;
      end else begin
        beat <= beat + 2'd1;
      end
    end
  end

  // The erase sequence is backspace, space, backspace.
  always_comb begin
    result       = held.res;
    result_valid = full;
    if (held.triple) begin
      result.echo_valid = 1'b1;
      result.echo_byte  = (beat == 2'd1) ? cle_pkg::CH_SPACE : cle_pkg::CH_BS;
      result.last       = (beat == 2'd2);
    end
  end

`ifndef SYNTHESIS
  a_beat_idle: assert property (@(posedge clk) disable iff (rst)
    !full |-> beat == 2'd0) else $error("beat counter not parked while empty");
  a_beat_range: assert property (@(posedge clk) disable iff (rst)
    full |-> beat != 2'd3) else $error("beat counter out of range");
  a_single_beat: assert property (@(posedge clk) disable iff (rst)
    (full && !held.triple) |-> beat == 2'd0) else $error("single item advanced beats");
  a_more_beats: assert property (@(posedge clk) disable iff (rst)
    (take_out && !done_beat) |=> full) else $error("erase sequence cut short");
`endif

endmodule

@@ rtl/console_line_editor.sv @@
// ----------------------------------------------------------------------------
// Console line editor
// Collects received characters into a line buffer with backspace editing,
// escape-sequence handling and a line-ready flag.
// ----------------------------------------------------------------------------
// Each item passes through the input register and then the output stage's
// holding register before its result is offered.
// Throughput: one item per cycle while results are taken; a backspace that
// erases a character holds the output stage for three result transfers.
// Reset clears the fill count, the ready flag and all pipeline valids; the
// line store itself is not cleared and needs no clearing pass.
module console_line_editor (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_ready,
  input  cle_pkg::item_t    item,
  output logic              result_valid,
  input  logic              result_ready,
  output cle_pkg::result_t  result
);

  // Editor state. The marks record, per buffer entry, whether it holds ESC or
  // '[', so the escape checks never have to wait on the RAM read port.
  logic [cle_pkg::LEN_W-1:0]      fill_count;
  logic                           ready_flag;
  logic [cle_pkg::LINE_DEPTH-1:0] esc_mark;
  logic [cle_pkg::LINE_DEPTH-1:0] seq_mark;

  // Input register stage. Buffer read data lines up with this stage.
  logic           s1_valid;
  cle_pkg::item_t s1_item;
  logic           s1_adv;
  logic           item_take;

  // Buffer RAM ports and same-cycle write bypass.
  logic                       wr_en;
  logic [cle_pkg::ADDR_W-1:0] wr_addr;
  logic [cle_pkg::ADDR_W-1:0] rd_addr;
  logic [7:0]                 ram_data;
  logic                       byp_hit;
  logic [7:0]                 byp_data;
  logic [7:0]                 rd_byte;

  // Decision logic results.
  logic [cle_pkg::LEN_W-1:0]  fill_next;
  logic                       ready_next;
  logic [cle_pkg::LEN_W-1:0]  fill_m1;
  logic [cle_pkg::LEN_W-1:0]  fill_m2;
  logic                       prev_esc;
  logic                       seq_tail;
  logic                       is_term;
  logic                       is_erase;
  cle_pkg::job_t              job;
  logic                       job_ready;

  assign item_take  = item_valid && item_ready;
  assign s1_adv     = s1_valid && job_ready;
  assign item_ready = !s1_valid || job_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item_ready) begin
      s1_valid <= item_valid;
    end
    if (item_take) begin
      s1_item  <= item;
      // The RAM returns old data when the write lands on the address being
      // read, so the freshly written byte is captured here instead.
      byp_hit  <= wr_en && (wr_addr == rd_addr);
      byp_data <= s1_item.ch;
    end
  end

  assign rd_addr = cle_pkg::ADDR_W'(item.index);
  assign wr_addr = fill_count[cle_pkg::ADDR_W-1:0];
  assign rd_byte = byp_hit ? byp_data : ram_data;

  cle_ram #(
    .WIDTH (8),
    .DEPTH (cle_pkg::LINE_DEPTH)
  ) u_line_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (s1_item.ch),
    .rd_en   (item_take),
    .rd_addr (rd_addr),
    .rd_data (ram_data)
  );

  // Escape lookups at the last two buffer positions.
  assign fill_m1  = fill_count - cle_pkg::LEN_W'(1);
  assign fill_m2  = fill_count - cle_pkg::LEN_W'(2);
  assign prev_esc = (fill_count != '0) && esc_mark[fill_m1[cle_pkg::ADDR_W-1:0]];
  assign seq_tail = (fill_count > cle_pkg::LEN_W'(1))
                    && esc_mark[fill_m2[cle_pkg::ADDR_W-1:0]]
                    && seq_mark[fill_m1[cle_pkg::ADDR_W-1:0]];
  assign is_term  = (s1_item.ch == cle_pkg::CH_NUL) || (s1_item.ch == cle_pkg::CH_LF)
                    || (s1_item.ch == cle_pkg::CH_CR);
  assign is_erase = (s1_item.ch == cle_pkg::CH_BS) || (s1_item.ch == cle_pkg::CH_DEL);

  // One pass of the editor for the item in the input register. The result
  // carries the state as it stands after this item.
  always_comb begin
    fill_next  = fill_count;
    ready_next = ready_flag;
    wr_en      = 1'b0;
    job        = '0;
    unique case (s1_item.cmd)
      cle_pkg::CMD_CLEAR: begin
        fill_next  = '0;
        ready_next = 1'b0;
      end
      cle_pkg::CMD_READ: begin
        if (cle_pkg::LEN_W'(s1_item.index) < fill_count) begin
          job.res.read_byte = rd_byte;
        end
      end
      cle_pkg::CMD_RECV: begin
        if (!ready_flag) begin
          priority if (is_term) begin
            ready_next = 1'b1;
          end else if (seq_tail) begin
            // The character after ESC '[' is swallowed with the sequence.
            fill_next = fill_m2;
          end else if (is_erase) begin
            if (fill_count != '0) begin
              fill_next  = fill_m1;
              job.triple = 1'b1;
            end
          end else if (fill_count < cle_pkg::LEN_W'(cle_pkg::LINE_DEPTH)) begin
            wr_en     = s1_adv;
            fill_next = fill_count + cle_pkg::LEN_W'(1);
            if ((s1_item.ch != cle_pkg::CH_ESC) && !prev_esc) begin
              job.res.echo_valid = 1'b1;
              job.res.echo_byte  = s1_item.ch;
            end
          end else begin
            job.res.status = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
    job.res.line_ready  = ready_next;
    job.res.line_length = fill_next;
    job.res.last        = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
      ready_flag <= 1'b0;
    end else if (s1_adv) begin
      fill_count <= fill_next;
      ready_flag <= ready_next;
    end
    if (wr_en) begin
      esc_mark[wr_addr] <= (s1_item.ch == cle_pkg::CH_ESC);
      seq_mark[wr_addr] <= (s1_item.ch == cle_pkg::CH_SEQ);
    end
  end

  cle_out u_out (
    .clk          (clk),
    .rst          (rst),
    .job_valid    (s1_valid),
    .job_ready    (job_ready),
    .job          (job),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= cle_pkg::LEN_W'(cle_pkg::LINE_DEPTH))
    else $error("fill count past buffer depth");
  a_write_room: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> fill_count < cle_pkg::LEN_W'(cle_pkg::LINE_DEPTH))
    else $error("buffer write with no room");
  a_state_hold: assert property (@(posedge clk) disable iff (rst)
    !s1_adv |=> ($stable(fill_count) && $stable(ready_flag)))
    else $error("editor state changed without an item");
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_adv) |=> (s1_valid && $stable(s1_item)))
    else $error("stalled item lost from input register");
`endif

endmodule

@@ test/tb_top.sv @@
// ----------------------------------------------------------------------------
// Console line editor testbench
// Drives received characters, clear and read commands into the line editor
// and checks every echo, status and read-back result against a behavioral
// copy of the editor kept inside the testbench.
// ----------------------------------------------------------------------------
module tb_top;

  // The command encoding leaves one value unused; the editor must treat it
  // as a no-op that still answers with one result.
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  // Longest receiver hold-off used to back up the pipeline.
  localparam int LONG_HOLD   = 300;
  // Watchdog on the whole run, far above the slowest legal run.
  localparam int CYCLE_LIMIT = 400000;
  // Cycles to wait after the last result, so that any stray result is caught.
  localparam int DRAIN_CYCLES = 16;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             item_valid = 1'b0;
  logic             item_ready;
  cle_pkg::item_t   item = '0;
  logic             result_valid;
  logic             result_ready = 1'b0;
  cle_pkg::result_t result;

  console_line_editor dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  always #10 clk = ~clk;

  // --------------------------------------------------------------------------
  // Behavioral copy of the editor state. Only entries below line_fill are
  // ever looked at, and those have always been written by a stored
  // character, so the store needs no reset value.
  // --------------------------------------------------------------------------
  logic [7:0] line_copy [cle_pkg::LINE_DEPTH];
  int         line_fill  = 0;
  logic       line_done  = 1'b0;

  // Results the editor still owes, oldest first.
  cle_pkg::result_t awaited_replies [$];

  int  live_items     = 0;  // transfers that the editor did not just ignore
  int  mismatch_count = 0;
  int  cycle_count    = 0;

  // Idle controls for the sender and the receiver, set by the tests.
  bit  send_idle_on = 1'b1;
  bit  take_idle_on = 1'b1;
  int  hold_asked   = 0;

  // Builds one reply from the state as it stands after the item.
  function automatic cle_pkg::result_t make_reply(input logic ev, input logic [7:0] eb,
                                                  input logic st, input logic [7:0] rb,
                                                  input logic fin);
    cle_pkg::result_t r;
    r.echo_valid  = ev;
    r.echo_byte   = ev ? eb : 8'h00;
    r.status      = st;
    r.line_ready  = line_done;
    r.line_length = cle_pkg::LEN_W'(line_fill);
    r.read_byte   = rb;
    r.last        = fin;
    return r;
  endfunction

  // Applies one accepted item to the state copy and queues the replies that
  // the editor must produce for it.
  task automatic edit_line(input cle_pkg::item_t it);
    logic       echo;
    logic [7:0] rb;
    echo = 1'b0;
    rb   = 8'h00;
    if (it.cmd == cle_pkg::CMD_CLEAR) begin
      line_fill = 0;
      line_done = 1'b0;
      live_items++;
      awaited_replies.push_back(make_reply(1'b0, 8'h00, 1'b0, 8'h00, 1'b1));
    end else if (it.cmd == cle_pkg::CMD_READ) begin
      if (int'(it.index) < line_fill) rb = line_copy[it.index];
      live_items++;
      awaited_replies.push_back(make_reply(1'b0, 8'h00, 1'b0, rb, 1'b1));
    end else if (it.cmd != cle_pkg::CMD_RECV || line_done) begin
      // Unused command or a finished line: nothing changes.
      awaited_replies.push_back(make_reply(1'b0, 8'h00, 1'b0, 8'h00, 1'b1));
    end else begin
      live_items++;
      if (it.ch == cle_pkg::CH_NUL || it.ch == cle_pkg::CH_LF || it.ch == cle_pkg::CH_CR) begin
        line_done = 1'b1;
        awaited_replies.push_back(make_reply(1'b0, 8'h00, 1'b0, 8'h00, 1'b1));
      end else if (line_fill > 1 && line_copy[line_fill-2] == cle_pkg::CH_ESC &&
                   line_copy[line_fill-1] == cle_pkg::CH_SEQ) begin
        // An ESC '[' pair swallows this character and is itself removed.
        line_fill -= 2;
        awaited_replies.push_back(make_reply(1'b0, 8'h00, 1'b0, 8'h00, 1'b1));
      end else if (it.ch == cle_pkg::CH_BS || it.ch == cle_pkg::CH_DEL) begin
        if (line_fill > 0) begin
          line_fill--;
          awaited_replies.push_back(make_reply(1'b1, cle_pkg::CH_BS, 1'b0, 8'h00, 1'b0));
          awaited_replies.push_back(make_reply(1'b1, cle_pkg::CH_SPACE, 1'b0, 8'h00, 1'b0));
          awaited_replies.push_back(make_reply(1'b1, cle_pkg::CH_BS, 1'b0, 8'h00, 1'b1));
        end else begin
          awaited_replies.push_back(make_reply(1'b0, 8'h00, 1'b0, 8'h00, 1'b1));
        end
      end else if (line_fill < cle_pkg::LINE_DEPTH) begin
        // ESC and the character right after a stored ESC go in silently.
        echo = (it.ch != cle_pkg::CH_ESC) &&
               (line_fill == 0 || line_copy[line_fill-1] != cle_pkg::CH_ESC);
        line_copy[line_fill] = it.ch;
        line_fill++;
        awaited_replies.push_back(make_reply(echo, it.ch, 1'b0, 8'h00, 1'b1));
      end else begin
        awaited_replies.push_back(make_reply(1'b0, 8'h00, 1'b1, 8'h00, 1'b1));
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Sender. The payload is set together with valid at a rising edge, and
  // valid stays high after a transfer unless the next call idles first, so
  // back-to-back items never see valid dropped and raised in one step.
  // --------------------------------------------------------------------------
  task automatic send_item(input cle_pkg::item_t it);
    int gap;
    if (send_idle_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 12);
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item       <= it;
    item_valid <= 1'b1;
    do @(posedge clk); while (!item_ready);
    edit_line(it);
  endtask

  task automatic send_recv(input logic [7:0] c);
    cle_pkg::item_t it;
    it.cmd   = cle_pkg::CMD_RECV;
    it.ch    = c;
    it.index = 6'($urandom_range(0, 63));
    send_item(it);
  endtask

  task automatic send_read(input logic [5:0] idx);
    cle_pkg::item_t it;
    it.cmd   = cle_pkg::CMD_READ;
    it.ch    = 8'($urandom_range(0, 255));
    it.index = idx;
    send_item(it);
  endtask

  task automatic send_clear();
    cle_pkg::item_t it;
    it.cmd   = cle_pkg::CMD_CLEAR;
    it.ch    = 8'($urandom_range(0, 255));
    it.index = 6'($urandom_range(0, 63));
    send_item(it);
  endtask

  function automatic logic [7:0] printable_char();
    return 8'($urandom_range(8'h20, 8'h7e));
  endfunction

  // One character of a line being typed: mostly printable text, with some
  // erasing and some escape sequences mixed in.
  task automatic type_char();
    int pick;
    pick = $urandom_range(0, 19);
    if (pick == 0) begin
      send_recv(cle_pkg::CH_BS);
    end else if (pick == 1) begin
      send_recv(cle_pkg::CH_DEL);
    end else if (pick == 2) begin
      send_recv(cle_pkg::CH_ESC);
      send_recv(cle_pkg::CH_SEQ);
      send_recv(8'($urandom_range(0, 255)));
    end else if (pick == 3) begin
      send_recv(cle_pkg::CH_ESC);
      send_recv(printable_char());
    end else begin
      send_recv(printable_char());
    end
  endtask

  // --------------------------------------------------------------------------
  // Receiver. It takes results with random stall bursts, and on request
  // holds off for a long stretch so that the editor fills up and stalls its
  // input. The hold-off is counted here, in its own process.
  // --------------------------------------------------------------------------
  initial begin
    int hold_left;
    int hold_done;
    int gap_left;
    hold_left = 0;
    hold_done = 0;
    gap_left  = 0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        result_ready <= 1'b0;
      end else if (hold_asked != hold_done) begin
        hold_done++;
        hold_left = LONG_HOLD - 1;
        result_ready <= 1'b0;
      end else if (gap_left > 0) begin
        gap_left--;
        result_ready <= 1'b0;
      end else if (take_idle_on && $urandom_range(0, 5) == 0) begin
        gap_left = $urandom_range(1, 12) - 1;
        result_ready <= 1'b0;
      end else begin
        result_ready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result checking. Every transfer on the result side is compared field by
  // field with the oldest awaited reply.
  // --------------------------------------------------------------------------
  task automatic report_mismatch(input string what, input int got, input int want);
    mismatch_count++;
    $display("MISMATCH cycle %0d: %s got 0x%0h, want 0x%0h", cycle_count, what, got, want);
  endtask

  always @(posedge clk) begin
    cle_pkg::result_t want;
    if (!rst && result_valid && result_ready) begin
      if (awaited_replies.size() == 0) begin
        report_mismatch("result with none awaited, line_length", int'(result.line_length), -1);
      end else begin
        want = awaited_replies.pop_front();
        if (result.echo_valid !== want.echo_valid)
          report_mismatch("echo_valid", int'(result.echo_valid), int'(want.echo_valid));
        if (result.echo_byte !== want.echo_byte)
          report_mismatch("echo_byte", int'(result.echo_byte), int'(want.echo_byte));
        if (result.status !== want.status)
          report_mismatch("status", int'(result.status), int'(want.status));
        if (result.line_ready !== want.line_ready)
          report_mismatch("line_ready", int'(result.line_ready), int'(want.line_ready));
        if (result.line_length !== want.line_length)
          report_mismatch("line_length", int'(result.line_length), int'(want.line_length));
        if (result.read_byte !== want.read_byte)
          report_mismatch("read_byte", int'(result.read_byte), int'(want.read_byte));
        if (result.last !== want.last)
          report_mismatch("last", int'(result.last), int'(want.last));
      end
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_top failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Tests.
  // --------------------------------------------------------------------------

  // Short directed sequence through every command and every editing rule.
  task automatic test_editing();
    cle_pkg::item_t it;
    send_recv(cle_pkg::CH_BS);   // erasing an empty line echoes nothing
    send_recv("A");
    send_recv(8'hff);
    send_read(6'd0);
    send_read(6'd1);
    send_read(6'd2);             // at the length, so it reads back zero
    send_recv(cle_pkg::CH_DEL);  // DEL erases like backspace
    send_recv(cle_pkg::CH_ESC);  // stored but silent
    send_recv("q");              // follows ESC, stored but silent
    send_recv(cle_pkg::CH_ESC);
    send_recv(cle_pkg::CH_SEQ);
    send_recv("Z");              // swallowed, ESC '[' removed
    send_recv(cle_pkg::CH_ESC);
    send_recv(cle_pkg::CH_SEQ);
    send_recv(cle_pkg::CH_BS);   // the pair is removed instead of erasing
    send_read(6'd63);
    it.cmd   = CMD_UNUSED;
    it.ch    = 8'hff;
    it.index = 6'h3f;
    send_item(it);
    send_recv(cle_pkg::CH_LF);   // line finished
    send_recv("x");              // ignored on a finished line
    send_recv(cle_pkg::CH_BS);
    send_clear();
    send_recv(cle_pkg::CH_NUL);
    send_clear();
    send_recv(cle_pkg::CH_CR);
    send_clear();
  endtask

  // Fills the buffer to the top, then pushes one character too many.
  task automatic test_full_buffer();
    repeat (cle_pkg::LINE_DEPTH) send_recv(printable_char());
    send_recv(printable_char());
    send_recv(cle_pkg::CH_ESC);
    send_read(6'd63);
    send_read(6'd0);
    send_recv(cle_pkg::CH_BS);
    send_recv(printable_char());
    send_read(6'd63);
    send_clear();
  endtask

  // Mostly well-formed lines with random content and random idling, mixed
  // with fully random items as noise.
  task automatic test_random_lines(input int item_goal);
    int             len;
    cle_pkg::item_t it;
    while (live_items < item_goal) begin
      send_idle_on = ($urandom_range(0, 3) != 0);
      take_idle_on = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 7) == 0) begin
        repeat ($urandom_range(1, 6)) begin
          it.cmd   = 2'($urandom_range(0, 3));
          it.ch    = 8'($urandom_range(0, 255));
          it.index = 6'($urandom_range(0, 63));
          send_item(it);
        end
      end
      // Now and then a line long enough to reach the top of the buffer.
      len = ($urandom_range(0, 15) == 0) ? $urandom_range(60, 70) : $urandom_range(0, 12);
      repeat (len) type_char();
      if ($urandom_range(0, 7) != 0) begin
        case ($urandom_range(0, 2))
          0: send_recv(cle_pkg::CH_NUL);
          1: send_recv(cle_pkg::CH_LF);
          default: send_recv(cle_pkg::CH_CR);
        endcase
        if ($urandom_range(0, 3) == 0) send_recv(8'($urandom_range(0, 255)));
      end
      repeat ($urandom_range(0, 3)) begin
        if (line_fill > 0 && $urandom_range(0, 2) != 0)
          send_read(6'($urandom_range(0, line_fill - 1)));
        else
          send_read(6'($urandom_range(0, 63)));
      end
      if ($urandom_range(0, 5) != 0) send_clear();
    end
  endtask

  // The receiver holds off for a long stretch while the sender keeps
  // offering items, so the editor backs up and drops item_ready.
  task automatic test_stall_pressure();
    send_idle_on = 1'b0;
    hold_asked <= hold_asked + 1;
    repeat (40) type_char();
    send_clear();
  endtask

  // Back-to-back transfers on both sides to finish the run.
  task automatic test_back_to_back();
    send_idle_on = 1'b0;
    take_idle_on = 1'b0;
    repeat (30) type_char();
    send_recv(cle_pkg::CH_CR);
    send_read(6'd0);
    send_read(6'($urandom_range(0, 63)));
    send_clear();
    repeat (10) type_char();
    send_clear();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_editing();
    test_full_buffer();
    test_random_lines(330);
    test_stall_pressure();
    test_back_to_back();

    // Stop offering right at the last transfer, wait for every awaited
    // reply, then let the pipeline run a little longer so that any stray
    // result still gets caught.
    item_valid <= 1'b0;
    while (awaited_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

@@ console_line_editor.f @@
rtl/cle_pkg.sv
rtl/cle_ram.sv
rtl/cle_out.sv
rtl/console_line_editor.sv
test/tb_top.sv
